[src/qrm_pkg.sv]
// Package: shared constants for the quaternion to rotation matrix block.
`timescale 1ns / 1ps
package qrm_pkg;
	localparam int DEF_IN_WIDTH = 16;
	localparam int DEF_OUT_WIDTH = 16;
	localparam logic [31:0] LIMIT_RESET = 32'd16;
endpackage

[src/quaternion_to_rotation_matrix.sv]
// Top level: pipelined quaternion to 3x3 rotation matrix converter.
// Stages from input word accept to output word valid, in order:
//   products, sums, magnitudes/threshold, then one quotient bit per restoring division stage.
// Throughput: one word per cycle while the skid is empty; nine dividers run in lockstep.
// Output register plus skid: s_tready never depends on m_tready; once the skid holds a word
// the pipeline freezes, and it moves again the cycle after m_tready drains the skid.
// Reset (arst_n low, asynchronous): all valid bits clear, limit_q returns to 16.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix
	import qrm_pkg::*;
#(
	parameter int IN_WIDTH = DEF_IN_WIDTH,
	parameter int OUT_WIDTH = DEF_OUT_WIDTH,
	localparam int TDI = ((4 * IN_WIDTH + 7) / 8) * 8,
	localparam int TDO = ((9 * OUT_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [TDI-1:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [TDO-1:0] m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic           m_tuser,   // degenerate
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata
);
	localparam int PW = 2 * IN_WIDTH;
	localparam int NW = PW + 1;
	localparam int SW = NW + 1;
	localparam int CW = (NW > 32) ? NW : 32;
	localparam int F = OUT_WIDTH - 2;
	localparam logic [OUT_WIDTH-1:0] ONE = OUT_WIDTH'(1) << F;
	localparam logic [OUT_WIDTH-1:0] MAXPOS = (OUT_WIDTH'(1) << (OUT_WIDTH - 1)) - OUT_WIDTH'(1);
	localparam logic [OUT_WIDTH-1:0] MAXNEG = OUT_WIDTH'(1) << (OUT_WIDTH - 1);

	logic [31:0] limit_q;
	logic en;

	logic signed [IN_WIDTH-1:0] w_in, x_in, y_in, z_in;
	assign w_in = s_tdata[IN_WIDTH-1:0];
	assign x_in = s_tdata[2*IN_WIDTH-1:IN_WIDTH];
	assign y_in = s_tdata[3*IN_WIDTH-1:2*IN_WIDTH];
	assign z_in = s_tdata[4*IN_WIDTH-1:3*IN_WIDTH];

	// stage 1: component products
	logic v_s1;
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	// stage 2: norm and numerators
	logic v_s2;
	logic [NW-1:0] n_s2;
	logic signed [SW-1:0] num_s2 [0:8];
	// stage 3: magnitudes, signs, threshold
	logic v_s3, deg_s3;
	logic [NW-1:0] n_s3;
	logic [NW-1:0] mag_s3 [0:8];
	logic [8:0] neg_s3;
	// division stages
	logic v_d [0:F];
	logic deg_d [0:F];
	logic [8:0] neg_d [0:F];
	logic [NW-1:0] n_d [0:F];
	logic [NW-1:0] r_d [0:F][0:8];
	logic [OUT_WIDTH-1:0] q_d [0:F][0:8];
	logic [NW-1:0] r_nx [1:F][0:8];
	logic ge_nx [1:F][0:8];

	// output register and skid
	logic out_v_q, sk_v_q;
	logic [TDO-1:0] out_data_q, sk_data_q;
	logic out_deg_q, sk_deg_q;
	logic [TDO-1:0] res_data;
	logic res_deg;

	assign en = !sk_v_q;
	assign s_tready = en;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 0; k <= F; k++) begin
				v_d[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_d[0] <= v_s3;
			for (int k = 1; k <= F; k++) begin
				v_d[k] <= v_d[k-1];
			end
		end
	end

	// one restoring step per stage: compare 2r against n
	always_comb begin
		for (int k = 1; k <= F; k++) begin
			for (int e = 0; e < 9; e++) begin
				ge_nx[k][e] = {r_d[k-1][e], 1'b0} >= {1'b0, n_d[k-1]};
				r_nx[k][e] = ge_nx[k][e] ? NW'({r_d[k-1][e], 1'b0} - {1'b0, n_d[k-1]})
				                         : NW'({r_d[k-1][e], 1'b0});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= w_in * w_in;
			xx_s1 <= x_in * x_in;
			yy_s1 <= y_in * y_in;
			zz_s1 <= z_in * z_in;
			xy_s1 <= x_in * y_in;
			wz_s1 <= w_in * z_in;
			xz_s1 <= x_in * z_in;
			wy_s1 <= w_in * y_in;
			yz_s1 <= y_in * z_in;
			wx_s1 <= w_in * x_in;

			n_s2 <= NW'(SW'(ww_s1) + SW'(xx_s1) + SW'(yy_s1) + SW'(zz_s1));
			num_s2[0] <= SW'(ww_s1) + SW'(xx_s1) - SW'(yy_s1) - SW'(zz_s1);
			num_s2[1] <= (SW'(xy_s1) - SW'(wz_s1)) <<< 1;
			num_s2[2] <= (SW'(xz_s1) + SW'(wy_s1)) <<< 1;
			num_s2[3] <= (SW'(xy_s1) + SW'(wz_s1)) <<< 1;
			num_s2[4] <= SW'(ww_s1) - SW'(xx_s1) + SW'(yy_s1) - SW'(zz_s1);
			num_s2[5] <= (SW'(yz_s1) - SW'(wx_s1)) <<< 1;
			num_s2[6] <= (SW'(xz_s1) - SW'(wy_s1)) <<< 1;
			num_s2[7] <= (SW'(yz_s1) + SW'(wx_s1)) <<< 1;
			num_s2[8] <= SW'(ww_s1) - SW'(xx_s1) - SW'(yy_s1) + SW'(zz_s1);

			n_s3 <= n_s2;
			deg_s3 <= CW'(n_s2) <= CW'(limit_q);
			for (int e = 0; e < 9; e++) begin
				neg_s3[e] <= num_s2[e][SW-1];
				mag_s3[e] <= num_s2[e][SW-1] ? NW'(-num_s2[e]) : NW'(num_s2[e]);
			end

			// integer part: mag never exceeds n
			n_d[0] <= n_s3;
			deg_d[0] <= deg_s3;
			neg_d[0] <= neg_s3;
			for (int e = 0; e < 9; e++) begin
				q_d[0][e] <= (mag_s3[e] >= n_s3) ? OUT_WIDTH'(1) : '0;
				r_d[0][e] <= (mag_s3[e] >= n_s3) ? NW'(mag_s3[e] - n_s3) : mag_s3[e];
			end
			for (int k = 1; k <= F; k++) begin
				n_d[k] <= n_d[k-1];
				deg_d[k] <= deg_d[k-1];
				neg_d[k] <= neg_d[k-1];
				for (int e = 0; e < 9; e++) begin
					r_d[k][e] <= r_nx[k][e];
					q_d[k][e] <= {q_d[k-1][e][OUT_WIDTH-2:0], ge_nx[k][e]};
				end
			end
		end
	end

	// round half away from zero, apply sign, saturate; identity when degenerate
	always_comb begin
		logic [OUT_WIDTH-1:0] qr;
		logic [OUT_WIDTH-1:0] ent;
		res_data = '0;
		res_deg = deg_d[F];
		for (int e = 0; e < 9; e++) begin
			qr = q_d[F][e] + OUT_WIDTH'({r_d[F][e], 1'b0} >= {1'b0, n_d[F]});
			if (neg_d[F][e]) begin
				ent = (qr > MAXNEG) ? MAXNEG : OUT_WIDTH'(-qr);
			end else begin
				ent = (qr > MAXPOS) ? MAXPOS : qr;
			end
			if (deg_d[F]) begin
				ent = (e == 0 || e == 4 || e == 8) ? ONE : '0;
			end
			res_data[e*OUT_WIDTH +: OUT_WIDTH] = ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (m_tready) begin
				sk_v_q <= 1'b0;
			end
		end else if (v_d[F]) begin
			if (out_v_q && !m_tready) begin
				sk_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (m_tready) begin
				out_data_q <= sk_data_q;
				out_deg_q <= sk_deg_q;
			end
		end else if (v_d[F]) begin
			if (out_v_q && !m_tready) begin
				sk_data_q <= res_data;
				sk_deg_q <= res_deg;
			end else begin
				out_data_q <= res_data;
				out_deg_q <= res_deg;
			end
		end
	end
endmodule

[src/qrm_checker.sv]
// Checker: port-level assertions for the rotation matrix block, with its bind.
`timescale 1ns / 1ps
module qrm_checker
	import qrm_pkg::*;
#(
	parameter int OUT_WIDTH = DEF_OUT_WIDTH,
	localparam int TDO = ((9 * OUT_WIDTH + 7) / 8) * 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tready,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [TDO-1:0] m_tdata,
	input logic           m_tuser
);
	localparam logic signed [OUT_WIDTH-1:0] ONE = OUT_WIDTH'(1) << (OUT_WIDTH - 2);
	logic signed [OUT_WIDTH-1:0] m00, m01, m11, m22;
	assign m00 = m_tdata[OUT_WIDTH-1:0];
	assign m01 = m_tdata[2*OUT_WIDTH-1:OUT_WIDTH];
	assign m11 = m_tdata[5*OUT_WIDTH-1:4*OUT_WIDTH];
	assign m22 = m_tdata[9*OUT_WIDTH-1:8*OUT_WIDTH];

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m00 == ONE && m11 == ONE && m22 == ONE && m01 == '0)
		else $error("degenerate word is not identity");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m00 <= ONE && m00 >= -ONE && m01 <= ONE && m01 >= -ONE)
		else $error("matrix entry outside unit range");

	a_trace: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> int'(m00) + int'(m11) + int'(m22) >= -int'(ONE) - 3)
		else $error("trace below -1");

	// with no word waiting at the output the skid is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output empty");
endmodule

bind quaternion_to_rotation_matrix qrm_checker #(
	.OUT_WIDTH(OUT_WIDTH)
) u_qrm_checker (.*);
